@@ hw/rtl/bis_pkg.sv @@
// Shared types and constants for the balanced interval splitter.
// Used by bis_ctrl, bis_datapath and the top level; depends on nothing else.
package bis_pkg;

  localparam int ADDR_W  = 24;
  localparam int LEN_W   = 25;
  localparam int GRAIN_W = 16;
  localparam int MAXP_W  = 4;
  localparam int MINE_W  = 24;
  localparam int WIDX_W  = 3;
  localparam int MAX_WORKERS = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRAIN = 2'd0;
  localparam logic [1:0] CFG_MAXP  = 2'd1;
  localparam logic [1:0] CFG_MINE  = 2'd2;

  // Division steps of the split setup and of each worker's range.
  localparam logic [2:0] OP_GROUPS = 3'd0;
  localparam logic [2:0] OP_PER    = 3'd1;
  localparam logic [2:0] OP_MING   = 3'd2;
  localparam logic [2:0] OP_MOST   = 3'd3;
  localparam logic [2:0] OP_ALT    = 3'd4;
  localparam logic [2:0] OP_WORK   = 3'd5;
  localparam logic [2:0] OP_GE     = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] region_begin;
    logic [LEN_W-1:0]  region_end;
    logic              last_region;
  } in_item_t;

  typedef struct packed {
    logic [WIDX_W-1:0] worker_index;
    logic [ADDR_W-1:0] piece_begin;
    logic [LEN_W-1:0]  piece_end;
    logic              worker_done;
    logic              last_piece;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       div_start;
    logic       div_take;
    logic [2:0] op;
    logic       emit_init;
    logic       acc_add;
    logic       mul;
    logic       range;
    logic       adv;
    logic       emit;
    logic       worker_next;
  } cmd_t;

  typedef struct packed {
    logic total_zero;
    logic min_on;
    logic div_done;
    logic rem_zero;
    logic need_adv;
    logic idx_end;
    logic out_free;
    logic last_worker;
  } status_t;

endpackage

@@ hw/rtl/bis_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for every split division.
module bis_divider #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // One subtract-and-compare per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= shifted[W-1:0];
      end
      quo <= {quo[W-2:0], !diff[W]};
    end
  end

endmodule

@@ hw/rtl/bis_datapath.sv @@
// Datapath: configuration, interval store, split arithmetic, piece output.
// Depends on bis_pkg and bis_divider; driven by bis_ctrl commands.
module bis_datapath
  import bis_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             sts,
  input  in_item_t            in_item,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [MINE_W-1:0]   cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int TOT_W = LEN_W + CNT_W;
  localparam int DIV_W = TOT_W + 4;
  localparam int PRD_W = TOT_W + GRAIN_W;
  localparam int WC_W  = MAXP_W;

  // Configuration registers.
  logic [GRAIN_W-1:0] grain_size;
  logic [MAXP_W-1:0]  max_partitions;
  logic [MINE_W-1:0]  min_elements;

  always_ff @(posedge clk) begin
    if (rst) begin
      grain_size     <= GRAIN_W'(1);
      max_partitions <= MAXP_W'(8);
      min_elements   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRAIN: grain_size     <= cfg_data[GRAIN_W-1:0];
        CFG_MAXP:  max_partitions <= cfg_data[MAXP_W-1:0];
        CFG_MINE:  min_elements   <= cfg_data;
        default:   ;
      endcase
    end
  end

  logic [GRAIN_W-1:0] g_eff;
  logic [MAXP_W-1:0]  mp_eff;

  assign g_eff = (grain_size == '0) ? GRAIN_W'(1) : grain_size;

  always_comb begin
    mp_eff = max_partitions;
    if (max_partitions == '0) begin
      mp_eff = MAXP_W'(1);
    end else if (max_partitions > MAXP_W'(MAX_WORKERS)) begin
      mp_eff = MAXP_W'(MAX_WORKERS);
    end
  end

  // Interval store and list totals.
  logic [ADDR_W-1:0] start_mem [MAX_REGIONS];
  logic [LEN_W-1:0]  len_mem   [MAX_REGIONS];
  logic [CNT_W-1:0]  count;
  logic [TOT_W-1:0]  total;
  logic [LEN_W-1:0]  in_len;
  logic              in_keep;

  assign in_len  = in_item.region_end - LEN_W'(in_item.region_begin);
  assign in_keep = (in_item.region_end > LEN_W'(in_item.region_begin)) &&
                   (count < CNT_W'(MAX_REGIONS));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      total <= '0;
    end else if (cmd.load && in_keep) begin
      count <= count + CNT_W'(1);
      total <= total + TOT_W'(in_len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_keep) begin
      start_mem[count[IDX_W-1:0]] <= in_item.region_begin;
      len_mem[count[IDX_W-1:0]]   <= in_len;
    end
  end

  // Read side of the store follows the next interval index.
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_next;
  logic [ADDR_W-1:0] cur_start;
  logic [LEN_W-1:0]  cur_len;

  always_comb begin
    idx_next = idx;
    if (cmd.emit_init) begin
      idx_next = '0;
    end else if (cmd.adv) begin
      idx_next = idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    cur_start <= start_mem[idx_next[IDX_W-1:0]];
    cur_len   <= len_mem[idx_next[IDX_W-1:0]];
  end

  // Shared divider and its operand selection.
  logic [TOT_W-1:0] groups;
  logic [TOT_W-1:0] per_part;
  logic [TOT_W-1:0] min_groups;
  logic [TOT_W-1:0] most;
  logic [WC_W-1:0]  workers;
  logic [DIV_W-1:0] acc;
  logic [TOT_W-1:0] ge;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W-1:0] div_quo;
  logic             div_done;
  logic [TOT_W-1:0] quo_t;

  assign quo_t = div_quo[TOT_W-1:0];

  always_comb begin
    div_num = DIV_W'(groups);
    div_den = DIV_W'(g_eff);
    unique case (cmd.op)
      OP_GROUPS: begin
        div_num = DIV_W'(total) + DIV_W'(g_eff) - DIV_W'(1);
        div_den = DIV_W'(g_eff);
      end
      OP_PER: begin
        div_num = DIV_W'(groups) + DIV_W'(mp_eff) - DIV_W'(1);
        div_den = DIV_W'(mp_eff);
      end
      OP_MING: begin
        div_num = DIV_W'(min_elements) + DIV_W'(g_eff) - DIV_W'(1);
        div_den = DIV_W'(g_eff);
      end
      OP_MOST: begin
        div_num = DIV_W'(groups);
        div_den = DIV_W'(min_groups);
      end
      OP_ALT: begin
        div_num = DIV_W'(groups) + DIV_W'(most) - DIV_W'(1);
        div_den = DIV_W'(most);
      end
      OP_WORK: begin
        div_num = DIV_W'(groups) + DIV_W'(per_part) - DIV_W'(1);
        div_den = DIV_W'(per_part);
      end
      OP_GE: begin
        div_num = acc;
        div_den = DIV_W'(workers);
      end
      default: ;
    endcase
  end

  bis_divider #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Quotients land in their destination register.
  always_ff @(posedge clk) begin
    if (cmd.div_take) begin
      unique case (cmd.op)
        OP_GROUPS: groups     <= quo_t;
        OP_PER:    per_part   <= quo_t;
        OP_MING:   min_groups <= quo_t;
        OP_MOST:   most       <= (quo_t == '0) ? TOT_W'(1) : quo_t;
        OP_ALT: begin
          if (quo_t > per_part) begin
            per_part <= quo_t;
          end
        end
        OP_WORK:   workers    <= quo_t[WC_W-1:0];
        OP_GE:     ge         <= quo_t;
        default:   ;
      endcase
    end
  end

  // Worker range: end grain times grain size, capped at the total.
  logic [WC_W-1:0]  w;
  logic [PRD_W-1:0] prod;
  logic [TOT_W-1:0] eb;
  logic [TOT_W-1:0] rem;
  logic [TOT_W-1:0] ee;
  logic [LEN_W-1:0] offset;

  assign ee = (prod > PRD_W'(total)) ? total : prod[TOT_W-1:0];

  // Piece cut from the current interval.
  logic [LEN_W-1:0] avail;
  logic [LEN_W-1:0] take;
  logic [LEN_W-1:0] pb;
  logic             wdone;
  logic             last_w;

  assign avail  = cur_len - offset;
  assign take   = (rem < TOT_W'(avail)) ? rem[LEN_W-1:0] : avail;
  assign pb     = LEN_W'(cur_start) + offset;
  assign wdone  = (rem == TOT_W'(take));
  assign last_w = ((w + WC_W'(1)) == workers);

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      acc    <= '0;
      eb     <= '0;
      w      <= '0;
      idx    <= '0;
      offset <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.acc_add) begin
        acc <= acc + DIV_W'(groups);
      end
      if (cmd.mul) begin
        prod <= PRD_W'(ge) * PRD_W'(g_eff);
      end
      if (cmd.range) begin
        rem <= ee - eb;
        eb  <= ee;
      end
      if (cmd.adv) begin
        offset <= '0;
      end else if (cmd.emit) begin
        offset <= offset + take;
        rem    <= rem - TOT_W'(take);
      end
      if (cmd.worker_next) begin
        w <= w + WC_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.worker_index <= w[WIDX_W-1:0];
      out_item.piece_begin  <= pb[ADDR_W-1:0];
      out_item.piece_end    <= pb + take;
      out_item.worker_done  <= wdone;
      out_item.last_piece   <= wdone && last_w;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.total_zero  = (total == '0);
    sts.min_on      = (min_elements != '0);
    sts.div_done    = div_done;
    sts.rem_zero    = (rem == '0);
    sts.need_adv    = (offset == cur_len);
    sts.idx_end     = (idx >= count);
    sts.out_free    = !out_valid || !out_stall;
    sts.last_worker = last_w;
  end

endmodule

@@ hw/rtl/bis_ctrl.sv @@
// Controller state machine sequencing load, setup divisions and emission.
// Depends on bis_pkg; drives bis_datapath through cmd_t / status_t.
module bis_ctrl
  import bis_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_ACC    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_RANGE  = 3'd6;
  localparam logic [2:0] S_PIECE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] op;
  logic [2:0] op_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_GROUPS;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.total_zero) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          op_next    = OP_GROUPS;
          state_next = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_DSTART;
          unique case (op)
            OP_GROUPS: op_next = OP_PER;
            OP_PER:    op_next = sts.min_on ? OP_MING : OP_WORK;
            OP_MING:   op_next = OP_MOST;
            OP_MOST:   op_next = OP_ALT;
            OP_ALT:    op_next = OP_WORK;
            OP_WORK: begin
              cmd.emit_init = 1'b1;
              state_next    = S_ACC;
            end
            default:   state_next = S_MUL;
          endcase
        end
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        op_next     = OP_GE;
        state_next  = S_DSTART;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RANGE;
      end
      S_RANGE: begin
        cmd.range  = 1'b1;
        state_next = S_PIECE;
      end
      S_PIECE: begin
        priority if (sts.rem_zero) begin
          if (sts.last_worker) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.worker_next = 1'b1;
            state_next      = S_ACC;
          end
        end else if (sts.idx_end) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (sts.need_adv) begin
          cmd.adv = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/balanced_interval_splitter_core.sv @@
// Top level of the balanced interval splitter.
// Depends on bis_pkg, bis_ctrl, bis_datapath and bis_divider.
//
//   channel  direction  handshake            payload
//   in       into core  in_valid / in_stall  in_item  (in_item_t)
//   out      from core  out_valid/out_stall  out_item (out_item_t)
//   cfg      into core  cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Intervals load at one item per cycle while the core is idle. After the final
// item the core checks the list total, then runs three setup divisions (six
// when a minimum share is set) and one division per worker on a shared
// bit-serial divider of TOT_W+4 bits. Each worker also takes an accumulate,
// a multiply and a range step; pieces go out one per cycle while the output is
// not stalled, and each change of interval takes a step of its own.
// Reset is synchronous and clears the list; the store needs no clearing.
// A stalled output holds its piece and the split waits; new items load once
// the split has finished.
module balanced_interval_splitter_core
  import bis_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [MINE_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_item.last_region),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bis_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
